// File: rtl/idm_pkg.sv
package idm_pkg;

  // Operand and result width in bits.
  localparam int unsigned DataWidth = 64;
  localparam int unsigned CntWidth  = $clog2(DataWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(DataWidth - 1);

  typedef enum logic [1:0] {
    FUNC_DIV  = 2'd0,
    FUNC_DIVU = 2'd1,
    FUNC_REM  = 2'd2,
    FUNC_REMU = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_FIXUP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic fix;
  } idm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } idm_status_t;

endpackage

// File: rtl/idm_datapath.sv
module idm_datapath
  import idm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  idm_cmd_t             cmd_i,
  output idm_status_t          status_o,
  input  logic [1:0]           func_i,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  output logic [DataWidth-1:0] result_o
);

  func_e                func_q;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] dvs_q, dvs_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] result_q, result_d;
  logic                 neg_rem_q, neg_quo_q, zero_q;
  logic [CntWidth-1:0]  cnt_q, cnt_d;

  logic                 is_signed;
  logic                 sign_a, sign_b;
  logic [DataWidth:0]   shifted;
  logic [DataWidth+1:0] diff;
  logic                 take;
  logic [DataWidth-1:0] rem_fixed, quo_fixed;

  assign is_signed = (func_q == FUNC_DIV) || (func_q == FUNC_REM);
  assign sign_a    = quo_q[DataWidth-1];
  assign sign_b    = dvs_q[DataWidth-1];

  // One restoring step; the extra top bit keeps the carry of the shift.
  assign shifted = {rem_q, quo_q[DataWidth-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign take    = ~diff[DataWidth+1];

  assign rem_fixed = neg_rem_q ? (DataWidth'(0) - rem_q) : rem_q;
  assign quo_fixed = zero_q ? {DataWidth{1'b1}}
                   : (neg_quo_q ? (DataWidth'(0) - quo_q) : quo_q);

  always_comb begin
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    result_d = result_q;
    if (cmd_i.load) begin
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end
    if (cmd_i.prep) begin
      if (is_signed && sign_a) quo_d = DataWidth'(0) - quo_q;
      if (is_signed && sign_b) dvs_d = DataWidth'(0) - dvs_q;
      rem_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.step) begin
      rem_d = take ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
      quo_d = {quo_q[DataWidth-2:0], take};
      cnt_d = cnt_q + CntWidth'(1);
    end
    if (cmd_i.fix) begin
      result_d = func_q[1] ? rem_fixed : quo_fixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    result_q <= result_d;
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
    end
    if (cmd_i.prep) begin
      neg_rem_q <= is_signed && sign_a;
      neg_quo_q <= is_signed && (sign_a ^ sign_b);
      zero_q    <= (dvs_q == '0);
    end
  end

  assign status_o.last = (cnt_q == LastStep);
  assign result_o      = result_q;

endmodule

// File: rtl/idm_controller.sv
module idm_controller
  import idm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output idm_cmd_t    cmd_o,
  input  idm_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (status_i.last) state_d = ST_FIXUP;
      end
      ST_FIXUP: begin
        // The result register is written only once the previous result has gone.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fix   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/integer_divide_modulo_64.sv
// Radix-2 restoring integer divider for 64-bit operands. Each input
// transaction carries an operation code (signed or unsigned divide, signed or
// unsigned remainder) and two operands; one result transaction follows. An
// operation runs from acceptance to the result register in three phases: a
// step that takes the operands to magnitudes, a shift-and-subtract for each
// of the 64 quotient bits in one subtractor of the datapath, one quotient bit
// per cycle, and the sign fix-up. The controller then returns to idle, where
// it takes the next operands, so a new operation is taken only once the last
// one has finished its fix-up. A finished result sits in an output
// register, so the next operation may be accepted while it waits; the fix-up
// of that next operation holds until the register is free. Signed quotients
// truncate toward zero and a signed remainder carries the sign of the
// dividend. A zero divisor gives an all-ones quotient and the dividend as the
// remainder; the most negative value divided by minus one gives the most
// negative value.
module integer_divide_modulo_64
  import idm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataWidth-1:0] result_o
);

  idm_cmd_t    cmd;
  idm_status_t status;

  // The controller sequences the phases and owns both handshakes.
  idm_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath holds the operands, the partial remainder and the result.
  idm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .func_i     (func_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .result_o   (result_o)
  );

endmodule

// File: rtl/idm_checker.sv
module idm_checker
  import idm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [1:0]           func_i,
  input logic [DataWidth-1:0] dividend_i,
  input logic [DataWidth-1:0] divisor_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [DataWidth-1:0] result_o
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed or dropped before it was taken");

  // Once an operation is taken the input side closes.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an operation is in progress");

  // In the last divide step of an operation the input side is still closed.
  a_busy_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##65 !in_ready_o)
    else $error("input reopened before the division finished");

  // A new result appears only at the end of an operation.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an operation in progress");

endmodule

bind integer_divide_modulo_64 idm_checker u_idm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .dividend_i  (dividend_i),
  .divisor_i   (divisor_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o)
);
